// ===== src/endstop_homing_sequencer_defines.svh =====
// Assertion macros shared by the homing sequencer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ENDSTOP_HOMING_SEQUENCER_DEFINES_SVH
`define ENDSTOP_HOMING_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EHS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ehs_pkg.sv =====
// Package of the endstop homing sequencer: phase and op codes, register
// indexes, reset defaults and the result record. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ehs_pkg;

  localparam int EHS_AXES            = 3;
  localparam int EHS_PERIOD_WIDTH    = 16;
  localparam int EHS_ITERATION_WIDTH = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int PORT_AXES   = 3;

  typedef enum logic [1:0] {
    PH_FAST    = 2'd0,
    PH_RETRACT = 2'd1,
    PH_SLOW    = 2'd2,
    PH_IDLE    = 2'd3
  } phase_t;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_HALT  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_ORDER  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOME_TO_MIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_PERIOD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_PERIOD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RETRACT_X   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_RETRACT_Y   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_RETRACT_Z   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LIMIT  = 3'd7;

  localparam logic [5:0]  RST_AXIS_ORDER  = 6'd0;
  localparam logic [2:0]  RST_HOME_TO_MIN = 3'd7;
  localparam logic [15:0] RST_FAST_PERIOD = 16'd250;
  localparam logic [15:0] RST_SLOW_PERIOD = 16'd500;
  localparam logic [15:0] RST_RETRACT_X   = 16'd400;
  localparam logic [15:0] RST_RETRACT_Y   = 16'd400;
  localparam logic [15:0] RST_RETRACT_Z   = 16'd1600;
  localparam logic [31:0] RST_STEP_LIMIT  = 32'd10000000;

  typedef struct packed {
    logic [PORT_AXES-1:0] step_pulse;
    logic [PORT_AXES-1:0] step_toward_min;
    logic                 busy_res;
    logic [1:0]           phase;
    logic                 finished;
    logic                 aborted;
  } result_t;

endpackage

`default_nettype wire

// ===== src/ehs_in_if.sv =====
// Input channel of the homing sequencer: tick, start and halt items.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface ehs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] min_endstops;
  logic [2:0] max_endstops;

  modport source (output valid, output op, output min_endstops, output max_endstops,
                  input ready);
  modport sink   (input valid, input op, input min_endstops, input max_endstops,
                  output ready);
endinterface

`default_nettype wire

// ===== src/ehs_out_if.sv =====
// Result channel of the homing sequencer: step pulses and status per item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface ehs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] step_pulse;
  logic [2:0] step_toward_min;
  logic       busy_res;
  logic [1:0] phase;
  logic       finished;
  logic       aborted;

  modport source (output valid, output step_pulse, output step_toward_min,
                  output busy_res, output phase, output finished, output aborted,
                  input ready);
  modport sink   (input valid, input step_pulse, input step_toward_min,
                  input busy_res, input phase, input finished, input aborted,
                  output ready);
endinterface

`default_nettype wire

// ===== src/endstop_homing_sequencer.sv =====
// Top level of the three-axis endstop homing sequencer.
// Depends on ehs_pkg, ehs_in_if, ehs_out_if and the assertion macro header.
//
// Usage: every input transfer carries an op (tick, start or halt) and the
// sampled min and max endstops. Each accepted item produces exactly one
// result transfer with the step pulses, their directions, the busy flag,
// the phase after the item and one-item finished and aborted flags.
// A start runs the axis groups through fast approach, retract and slow
// approach; the step timing counts tick items, not clock cycles.
// The result of an item is offered on the cycle after its transfer.
// Throughput is one item per cycle while results are taken; the state update
// for an item is one pass of logic between the state registers and the result
// register. The result register lets a new item be taken in the same cycle
// in which the waiting result is taken. When the receiver stalls, the result
// holds and in_if.ready drops until it is taken. The user must write
// configuration via cfg_we, cfg_index and cfg_wdata only while no cycle runs;
// the block does not enforce this. Synchronous reset loads the register
// defaults and returns the sequencer to idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "endstop_homing_sequencer_defines.svh"

module endstop_homing_sequencer #(
  parameter int AXES            = ehs_pkg::EHS_AXES,
  parameter int PERIOD_WIDTH    = ehs_pkg::EHS_PERIOD_WIDTH,
  parameter int ITERATION_WIDTH = ehs_pkg::EHS_ITERATION_WIDTH
) (
  input  wire                            clk,
  input  wire                            rst_n,
  ehs_in_if.sink                         in_if,
  ehs_out_if.source                      out_if,
  input  wire                            cfg_we,
  input  wire [ehs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [ehs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PSW = (PERIOD_WIDTH < 16) ? PERIOD_WIDTH : 16;
  localparam int LSW = (ITERATION_WIDTH < 32) ? ITERATION_WIDTH : 32;

  logic [5:0]                 axis_order_r;
  logic [2:0]                 home_to_min_r;
  logic [PSW-1:0]             fast_period_r;
  logic [PSW-1:0]             slow_period_r;
  logic [15:0]                retract_r [3];
  logic [LSW-1:0]             step_limit_r;

  ehs_pkg::phase_t            phase_r, phase_nxt;
  logic [5:0]                 rem_r, rem_nxt;
  logic [AXES-1:0]            group_r, group_nxt;
  logic [PERIOD_WIDTH-1:0]    div_r, div_nxt;
  logic [ITERATION_WIDTH-1:0] iter_r, iter_nxt;

  ehs_pkg::result_t           out_r, out_nxt;
  logic                       out_valid_r;

  logic                       in_fire;
  logic                       busy;
  logic                       do_iter;
  logic [PSW-1:0]             per_eff;
  logic [LSW-1:0]             limit_eff;
  logic [ITERATION_WIDTH-1:0] iter_inc;
  logic [AXES-1:0]            pulse;
  logic [AXES-1:0]            dirmin;
  logic                       fin;
  logic                       ab;

  function automatic logic [AXES-1:0] axis_mask(input logic [1:0] a);
    logic [AXES-1:0] m;
    m = '0;
    if (32'(a) < AXES) begin
      m = AXES'(4'b0001 << a);
    end
    return m;
  endfunction

  assign in_fire     = in_if.valid && in_if.ready;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign busy        = (phase_r != ehs_pkg::PH_IDLE);
  assign do_iter     = in_fire && (in_if.op == ehs_pkg::OP_TICK) && busy && (div_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_order_r  <= ehs_pkg::RST_AXIS_ORDER;
      home_to_min_r <= ehs_pkg::RST_HOME_TO_MIN;
      fast_period_r <= PSW'(ehs_pkg::RST_FAST_PERIOD);
      slow_period_r <= PSW'(ehs_pkg::RST_SLOW_PERIOD);
      retract_r[0]  <= ehs_pkg::RST_RETRACT_X;
      retract_r[1]  <= ehs_pkg::RST_RETRACT_Y;
      retract_r[2]  <= ehs_pkg::RST_RETRACT_Z;
      step_limit_r  <= LSW'(ehs_pkg::RST_STEP_LIMIT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ehs_pkg::CFG_AXIS_ORDER:  axis_order_r  <= cfg_wdata[5:0];
        ehs_pkg::CFG_HOME_TO_MIN: home_to_min_r <= cfg_wdata[2:0];
        ehs_pkg::CFG_FAST_PERIOD: fast_period_r <= PSW'(cfg_wdata[15:0]);
        ehs_pkg::CFG_SLOW_PERIOD: slow_period_r <= PSW'(cfg_wdata[15:0]);
        ehs_pkg::CFG_RETRACT_X:   retract_r[0]  <= cfg_wdata[15:0];
        ehs_pkg::CFG_RETRACT_Y:   retract_r[1]  <= cfg_wdata[15:0];
        ehs_pkg::CFG_RETRACT_Z:   retract_r[2]  <= cfg_wdata[15:0];
        ehs_pkg::CFG_STEP_LIMIT:  step_limit_r  <= LSW'(cfg_wdata);
      endcase
    end
  end

  // Step decisions of one iteration.
  always_comb begin
    logic trig;
    trig      = 1'b0;
    per_eff   = (phase_r == ehs_pkg::PH_FAST) ? fast_period_r : slow_period_r;
    if (per_eff == '0) begin
      per_eff = PSW'(1);
    end
    limit_eff = (step_limit_r == '0) ? LSW'(1) : step_limit_r;
    iter_inc  = (iter_r != '1) ? iter_r + 1'b1 : iter_r;
    pulse     = '0;
    dirmin    = '0;
    for (int c = 0; c < AXES; c++) begin
      if (group_r[c]) begin
        if (phase_r == ehs_pkg::PH_RETRACT) begin
          if (iter_r < ITERATION_WIDTH'(retract_r[c])) begin
            pulse[c]  = 1'b1;
            dirmin[c] = !home_to_min_r[c];
          end
        end else begin
          trig = home_to_min_r[c] ? in_if.min_endstops[c] : in_if.max_endstops[c];
          if (!trig) begin
            pulse[c]  = 1'b1;
            dirmin[c] = home_to_min_r[c];
          end
        end
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    group_nxt = group_r;
    div_nxt   = div_r;
    iter_nxt  = iter_r;
    fin       = 1'b0;
    ab        = 1'b0;
    priority if (in_fire && in_if.op == ehs_pkg::OP_START && !busy) begin
      if (axis_order_r == '0) begin
        group_nxt = '1;
        rem_nxt   = '0;
      end else begin
        group_nxt = axis_mask(axis_order_r[1:0]);
        rem_nxt   = {2'b00, axis_order_r[5:2]};
      end
      phase_nxt = ehs_pkg::PH_FAST;
      div_nxt   = '0;
      iter_nxt  = '0;
    end else if (in_fire && in_if.op == ehs_pkg::OP_HALT && busy) begin
      phase_nxt = ehs_pkg::PH_IDLE;
      rem_nxt   = '0;
      group_nxt = '0;
      div_nxt   = '0;
      iter_nxt  = '0;
      ab        = 1'b1;
    end else if (in_fire && in_if.op == ehs_pkg::OP_TICK && busy && div_r != '0) begin
      div_nxt = div_r - 1'b1;
    end else if (do_iter) begin
      iter_nxt = iter_inc;
      div_nxt  = PERIOD_WIDTH'(per_eff - 1'b1);
      if (pulse == '0 || iter_inc >= ITERATION_WIDTH'(limit_eff)) begin
        iter_nxt = '0;
        unique case (phase_r)
          ehs_pkg::PH_FAST:    phase_nxt = ehs_pkg::PH_RETRACT;
          ehs_pkg::PH_RETRACT: phase_nxt = ehs_pkg::PH_SLOW;
          ehs_pkg::PH_SLOW: begin
            if (rem_r != '0) begin
              group_nxt = axis_mask(rem_r[1:0]);
              rem_nxt   = {2'b00, rem_r[5:2]};
              phase_nxt = ehs_pkg::PH_FAST;
            end else begin
              phase_nxt = ehs_pkg::PH_IDLE;
              rem_nxt   = '0;
              group_nxt = '0;
              div_nxt   = '0;
              fin       = 1'b1;
            end
          end
          ehs_pkg::PH_IDLE:    phase_nxt = ehs_pkg::PH_IDLE;
        endcase
      end
    end else begin
      phase_nxt = phase_r;
    end
  end

  always_comb begin
    out_nxt.step_pulse      = do_iter ? ehs_pkg::PORT_AXES'(pulse) : '0;
    out_nxt.step_toward_min = do_iter ? ehs_pkg::PORT_AXES'(dirmin) : '0;
    out_nxt.busy_res        = (phase_nxt != ehs_pkg::PH_IDLE);
    out_nxt.phase           = phase_nxt;
    out_nxt.finished        = fin;
    out_nxt.aborted         = ab;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ehs_pkg::PH_IDLE;
      rem_r       <= '0;
      group_r     <= '0;
      div_r       <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        rem_r       <= rem_nxt;
        group_r     <= group_nxt;
        div_r       <= div_nxt;
        iter_r      <= iter_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.step_pulse      = out_r.step_pulse;
  assign out_if.step_toward_min = out_r.step_toward_min;
  assign out_if.busy_res        = out_r.busy_res;
  assign out_if.phase           = out_r.phase;
  assign out_if.finished        = out_r.finished;
  assign out_if.aborted         = out_r.aborted;

  `EHS_ASSERT_NEXT(a_halt_goes_idle, clk, rst_n, in_fire && in_if.op == ehs_pkg::OP_HALT, phase_r == ehs_pkg::PH_IDLE, "halt transfer did not leave the sequencer idle")
  `EHS_ASSERT_IMPL(a_idle_counters_clear, clk, rst_n, phase_r == ehs_pkg::PH_IDLE, div_r == '0 && iter_r == '0 && group_r == '0, "idle sequencer holds stale counters")
  `EHS_ASSERT_IMPL(a_finish_is_idle, clk, rst_n, out_valid_r && (out_r.finished || out_r.aborted), out_r.phase == ehs_pkg::PH_IDLE && !out_r.busy_res && !(out_r.finished && out_r.aborted), "completion result is not idle")
  `EHS_ASSERT_IMPL(a_dir_needs_pulse, clk, rst_n, out_valid_r, (out_r.step_toward_min & ~out_r.step_pulse) == '0, "direction bit set on an axis without a step")

endmodule

`default_nettype wire
